@@ hw/rtl/uvs_pkg.sv @@
// Shared types, constants and helpers for the UV sphere vertex generator.
package uvs_pkg;

    localparam int CNT_W         = 11;
    localparam int IDX_W         = 11;
    localparam int RAD_W         = 16;
    localparam int POS_W         = 17;
    localparam int NRM_W         = 16;
    localparam int TEX_W         = 17;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_DIVISIONS = 1024;

    localparam int PHASE_W    = 24;
    localparam int QUO_W      = 26;
    localparam int DIV_STAGES = QUO_W;
    localparam int SIN_STAGES = 7;
    localparam int Q30_W      = 31;
    // input stage, divider, phase stage, sine, four arithmetic stages
    localparam int PIPE_DEPTH = 1 + DIV_STAGES + 1 + SIN_STAGES + 4;
    localparam int TEX_DELAY  = SIN_STAGES + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [CNT_W-1:0] STACK_COUNT_RST  = 11'd16;
    localparam logic [CNT_W-1:0] SECTOR_COUNT_RST = 11'd32;
    localparam logic [RAD_W-1:0] RADIUS_RST       = 16'd256;

    typedef logic [Q30_W-1:0] q30_t;

    localparam q30_t ONE_Q30 = 31'h4000_0000;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 24'h40_0000;

    // Odd sine polynomial coefficients, highest order first (Horner order)
    localparam q30_t SIN_COEF [0:4] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
    };

    typedef struct packed {
        logic neg;
        q30_t mag;
    } sval_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        begin
            if (c == '0) begin
                r = CNT_W'(1);
            end else if (c > CNT_W'(MAX_DIVISIONS)) begin
                r = CNT_W'(MAX_DIVISIONS);
            end else begin
                r = c;
            end
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/uv_sphere_vertex_generator_unit.sv @@
// Top level of the UV sphere vertex generator.
//
// Input channel s_*: one grid point (stack index, sector index) per transaction.
// Output channel m_*: one vertex per input transaction, in order: position
// (signed Q8.8), unit normal (signed Q1.15) and texture coordinates (unsigned Q1.16).
// Config port cfg_*: register 0 stack count, 1 sector count, 2 radius; writes
// take effect at once; the user makes them only while the pipeline is empty.
// The block itself has no check for it. From accept to m_valid a vertex passes
// one input stage, a 26-stage divider (one quotient bit per stage), the phase
// stage, a 7-stage sine evaluator (a multiply in every stage but the first) and
// four product/rounding stages. One vertex per cycle unless the receiver stalls.
// When the receiver stalls with a vertex waiting, the whole pipeline holds
// and s_ready drops; nothing is dropped or repeated. Bubbles do not hold.
// Synchronous reset empties the pipeline and loads the default counts
// (16 stacks, 32 sectors) and radius 1.0.
module uv_sphere_vertex_generator_unit (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]          cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [uvs_pkg::IDX_W-1:0]          s_stack_index,
    input  logic [uvs_pkg::IDX_W-1:0]          s_sector_index,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [uvs_pkg::POS_W-1:0]   m_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]   m_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]   m_pos_z,
    output logic signed [uvs_pkg::NRM_W-1:0]   m_normal_x,
    output logic signed [uvs_pkg::NRM_W-1:0]   m_normal_y,
    output logic signed [uvs_pkg::NRM_W-1:0]   m_normal_z,
    output logic [uvs_pkg::TEX_W-1:0]          m_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]          m_tex_v
);

    function automatic logic [uvs_pkg::POS_W-1:0] apply_pos(
        input logic neg, input logic [uvs_pkg::POS_W-2:0] m);
        logic [uvs_pkg::POS_W-1:0] ext;
        begin
            ext = {1'b0, m};
            return neg ? (uvs_pkg::POS_W'(0) - ext) : ext;
        end
    endfunction

    function automatic logic [uvs_pkg::NRM_W-1:0] apply_nrm(
        input logic neg, input logic [uvs_pkg::NRM_W-1:0] n);
        logic [uvs_pkg::NRM_W:0] ext;
        logic [uvs_pkg::NRM_W-1:0] r;
        begin
            ext = (uvs_pkg::NRM_W+1)'(0) - {1'b0, n};
            if (neg) begin
                r = ext[uvs_pkg::NRM_W-1:0];
            end else if (n[uvs_pkg::NRM_W-1]) begin
                r = 16'h7FFF;  // +1.0 saturates
            end else begin
                r = n;
            end
            return r;
        end
    endfunction

    // configuration
    logic [uvs_pkg::CNT_W-1:0] stack_count_reg;
    logic [uvs_pkg::CNT_W-1:0] sector_count_reg;
    logic [uvs_pkg::RAD_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_count_reg  <= uvs_pkg::STACK_COUNT_RST;
            sector_count_reg <= uvs_pkg::SECTOR_COUNT_RST;
            radius_reg       <= uvs_pkg::RADIUS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                uvs_pkg::CFG_STACK_COUNT:  stack_count_reg  <= cfg_wdata[uvs_pkg::CNT_W-1:0];
                uvs_pkg::CFG_SECTOR_COUNT: sector_count_reg <= cfg_wdata[uvs_pkg::CNT_W-1:0];
                uvs_pkg::CFG_RADIUS:       radius_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [uvs_pkg::CNT_W-1:0] stacks;
    logic [uvs_pkg::CNT_W-1:0] sectors;

    assign stacks  = uvs_pkg::eff_count(stack_count_reg);
    assign sectors = uvs_pkg::eff_count(sector_count_reg);

    // pipeline control
    logic vld_reg [0:uvs_pkg::PIPE_DEPTH-1];
    logic pipe_en;

    assign pipe_en = !vld_reg[uvs_pkg::PIPE_DEPTH-1] || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = vld_reg[uvs_pkg::PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < uvs_pkg::PIPE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (pipe_en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < uvs_pkg::PIPE_DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // input stage: clamp indices to the effective counts
    logic [uvs_pkg::IDX_W-1:0] st_reg;
    logic [uvs_pkg::IDX_W-1:0] se_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st_reg <= (s_stack_index  > stacks)  ? stacks  : s_stack_index;
            se_reg <= (s_sector_index > sectors) ? sectors : s_sector_index;
        end
    end

    // index / count in Q25
    logic [uvs_pkg::QUO_W-1:0] quo_t;
    logic [uvs_pkg::QUO_W-1:0] quo_p;

    uvs_div u_div_stack (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (st_reg),
        .den  (stacks),
        .quo  (quo_t)
    );

    uvs_div u_div_sector (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (se_reg),
        .den  (sectors),
        .quo  (quo_p)
    );

    // phase stage: round to Q24 turns (polar is half of a turn) and to Q16
    logic [uvs_pkg::QUO_W:0]    ph_t_sum;
    logic [uvs_pkg::QUO_W:0]    ph_p_sum;
    logic [uvs_pkg::QUO_W-8:0]  tv_sum;
    logic [uvs_pkg::QUO_W-8:0]  tu_sum;
    logic [uvs_pkg::PHASE_W-1:0] ph_t;
    logic [uvs_pkg::PHASE_W-1:0] ph_p;

    assign ph_t_sum = {1'b0, quo_t} + (uvs_pkg::QUO_W+1)'(2);
    assign ph_p_sum = {1'b0, quo_p} + (uvs_pkg::QUO_W+1)'(1);
    assign tv_sum   = {1'b0, quo_t[uvs_pkg::QUO_W-1:8]} + (uvs_pkg::QUO_W-7)'(1);
    assign tu_sum   = {1'b0, quo_p[uvs_pkg::QUO_W-1:8]} + (uvs_pkg::QUO_W-7)'(1);
    assign ph_t     = ph_t_sum[uvs_pkg::PHASE_W+1:2];
    assign ph_p     = ph_p_sum[uvs_pkg::PHASE_W:1];  // full turn wraps to zero

    logic [uvs_pkg::PHASE_W-1:0] ph_ts_reg, ph_tc_reg, ph_ps_reg, ph_pc_reg;
    logic [uvs_pkg::TEX_W-1:0]   texu_reg [0:uvs_pkg::TEX_DELAY];
    logic [uvs_pkg::TEX_W-1:0]   texv_reg [0:uvs_pkg::TEX_DELAY];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ph_ts_reg   <= ph_t;
            ph_tc_reg   <= ph_t + uvs_pkg::QUARTER_TURN;
            ph_ps_reg   <= ph_p;
            ph_pc_reg   <= ph_p + uvs_pkg::QUARTER_TURN;
            texu_reg[0] <= tu_sum[uvs_pkg::TEX_W:1];
            texv_reg[0] <= tv_sum[uvs_pkg::TEX_W:1];
            for (int i = 1; i <= uvs_pkg::TEX_DELAY; i++) begin
                texu_reg[i] <= texu_reg[i-1];
                texv_reg[i] <= texv_reg[i-1];
            end
        end
    end

    uvs_pkg::sval_t sin_t, cos_t, sin_p, cos_p;

    uvs_sine u_sin_t (.aclk(aclk), .en(pipe_en), .phase(ph_ts_reg), .result(sin_t));
    uvs_sine u_cos_t (.aclk(aclk), .en(pipe_en), .phase(ph_tc_reg), .result(cos_t));
    uvs_sine u_sin_p (.aclk(aclk), .en(pipe_en), .phase(ph_ps_reg), .result(sin_p));
    uvs_sine u_cos_p (.aclk(aclk), .en(pipe_en), .phase(ph_pc_reg), .result(cos_p));

    // direction products
    logic [61:0]    pdx_reg, pdy_reg;
    logic           sx_d_reg, sy_d_reg;
    uvs_pkg::sval_t dz_d_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pdx_reg  <= sin_t.mag * cos_p.mag;
            pdy_reg  <= sin_t.mag * sin_p.mag;
            sx_d_reg <= sin_t.neg ^ cos_p.neg;
            sy_d_reg <= sin_t.neg ^ sin_p.neg;
            dz_d_reg <= cos_t;
        end
    end

    logic [61:0]    pdx_rnd, pdy_rnd;
    uvs_pkg::q30_t  dxm_reg, dym_reg;
    logic           sx_e_reg, sy_e_reg;
    uvs_pkg::sval_t dz_e_reg;

    assign pdx_rnd = pdx_reg + 62'h2000_0000;
    assign pdy_rnd = pdy_reg + 62'h2000_0000;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dxm_reg  <= pdx_rnd[60:30];
            dym_reg  <= pdy_rnd[60:30];
            sx_e_reg <= sx_d_reg;
            sy_e_reg <= sy_d_reg;
            dz_e_reg <= dz_d_reg;
        end
    end

    // radius products and normal rounding
    logic [31:0] nx_sum, ny_sum, nz_sum;
    logic [46:0] px_reg, py_reg, pz_reg;
    logic [uvs_pkg::NRM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic sx_f_reg, sy_f_reg, sz_f_reg;

    assign nx_sum = {1'b0, dxm_reg}      + 32'd16384;
    assign ny_sum = {1'b0, dym_reg}      + 32'd16384;
    assign nz_sum = {1'b0, dz_e_reg.mag} + 32'd16384;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            px_reg   <= radius_reg * dxm_reg;
            py_reg   <= radius_reg * dym_reg;
            pz_reg   <= radius_reg * dz_e_reg.mag;
            nx_reg   <= nx_sum[30:15];
            ny_reg   <= ny_sum[30:15];
            nz_reg   <= nz_sum[30:15];
            sx_f_reg <= sx_e_reg;
            sy_f_reg <= sy_e_reg;
            sz_f_reg <= dz_e_reg.neg;
        end
    end

    // output stage
    logic [47:0] px_rnd, py_rnd, pz_rnd;

    assign px_rnd = {1'b0, px_reg} + 48'h2000_0000;
    assign py_rnd = {1'b0, py_reg} + 48'h2000_0000;
    assign pz_rnd = {1'b0, pz_reg} + 48'h2000_0000;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_pos_x    <= apply_pos(sx_f_reg, px_rnd[45:30]);
            m_pos_y    <= apply_pos(sy_f_reg, py_rnd[45:30]);
            m_pos_z    <= apply_pos(sz_f_reg, pz_rnd[45:30]);
            m_normal_x <= apply_nrm(sx_f_reg, nx_reg);
            m_normal_y <= apply_nrm(sy_f_reg, ny_reg);
            m_normal_z <= apply_nrm(sz_f_reg, nz_reg);
        end
    end

    assign m_tex_u = texu_reg[uvs_pkg::TEX_DELAY];
    assign m_tex_v = texv_reg[uvs_pkg::TEX_DELAY];

    // checks
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_tex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tex_u <= 17'd65536 && m_tex_v <= 17'd65536))
        else $error("texture coordinate above one");

    a_sign_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pos_x < 0) |-> (m_normal_x <= 0))
        else $error("position x and normal x disagree in sign");

    // a large radius can lift a direction that rounds to a zero normal
    a_sign_z: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pos_z > 0) |-> (m_normal_z >= 0))
        else $error("position z and normal z disagree in sign");

endmodule

@@ hw/rtl/uvs_div.sv @@
// Pipelined restoring divider: quo = floor(num * 2^(QUO_W-1) / den), num <= den.
module uvs_div (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [uvs_pkg::CNT_W-1:0]      num,
    input  logic [uvs_pkg::CNT_W-1:0]      den,
    output logic [uvs_pkg::QUO_W-1:0]      quo
);

    logic [uvs_pkg::CNT_W-1:0] rem_reg [0:uvs_pkg::DIV_STAGES-1];
    logic [uvs_pkg::QUO_W-1:0] quo_reg [0:uvs_pkg::DIV_STAGES-1];

    // first stage: integer bit, num never exceeds den
    always_ff @(posedge aclk) begin
        if (en) begin
            if (num >= den) begin
                rem_reg[0] <= num - den;
                quo_reg[0] <= uvs_pkg::QUO_W'(1);
            end else begin
                rem_reg[0] <= num;
                quo_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 1; i < uvs_pkg::DIV_STAGES; i++) begin : g_stage
            logic [uvs_pkg::CNT_W-1:0] trial;
            // remainder stays below den <= 1024, so the top bit is free
            assign trial = {rem_reg[i-1][uvs_pkg::CNT_W-2:0], 1'b0};

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (trial >= den) begin
                        rem_reg[i] <= trial - den;
                        quo_reg[i] <= {quo_reg[i-1][uvs_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        rem_reg[i] <= trial;
                        quo_reg[i] <= {quo_reg[i-1][uvs_pkg::QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[uvs_pkg::DIV_STAGES-1];

endmodule

@@ hw/rtl/uvs_sine.sv @@
// Pipelined fixed-point sine of a Q0.24 turn phase, sign-magnitude Q30 result.
module uvs_sine (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [uvs_pkg::PHASE_W-1:0]   phase,
    output uvs_pkg::sval_t                result
);

    uvs_pkg::q30_t u_reg   [0:5];
    uvs_pkg::q30_t u2_reg  [0:3];
    uvs_pkg::q30_t t_reg   [0:3];
    logic          neg_reg [0:5];

    logic [22:0]   fold;
    logic [61:0]   sq;
    logic [61:0]   fin;
    uvs_pkg::q30_t fin_q;

    // odd quadrants mirror the phase inside the quarter turn
    always_comb begin
        if (phase[22]) begin
            fold = 23'h40_0000 - {1'b0, phase[21:0]};
        end else begin
            fold = {1'b0, phase[21:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0]   <= {fold, 8'b0};
            neg_reg[0] <= phase[23];
        end
    end

    assign sq = u_reg[0] * u_reg[0];

    always_ff @(posedge aclk) begin
        if (en) begin
            u2_reg[0]  <= sq[60:30];
            u_reg[1]   <= u_reg[0];
            neg_reg[1] <= neg_reg[0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_horner
            uvs_pkg::q30_t mcand;
            logic [61:0]   prod;

            if (k == 0) begin : g_first
                assign mcand = uvs_pkg::SIN_COEF[0];
            end else begin : g_next
                assign mcand = t_reg[k-1];
            end

            assign prod = u2_reg[k] * mcand;

            always_ff @(posedge aclk) begin
                if (en) begin
                    t_reg[k]     <= uvs_pkg::SIN_COEF[k+1] - prod[60:30];
                    u_reg[k+2]   <= u_reg[k+1];
                    neg_reg[k+2] <= neg_reg[k+1];
                end
            end

            if (k < 3) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        u2_reg[k+1] <= u2_reg[k];
                    end
                end
            end
        end
    endgenerate

    assign fin   = u_reg[5] * t_reg[3];
    assign fin_q = fin[60:30];

    always_ff @(posedge aclk) begin
        if (en) begin
            result.neg <= neg_reg[5];
            result.mag <= (fin_q > uvs_pkg::ONE_Q30) ? uvs_pkg::ONE_Q30 : fin_q;
        end
    end

endmodule
